### src/space_vector_pwm_duty_top_macros.svh
// ----------------------------------------------------------------------------
// Space vector PWM duty: assertion macros
// Shared concurrent assertion forms for the duty pipeline.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_DUTY_TOP_MACROS_SVH
`define SPACE_VECTOR_PWM_DUTY_TOP_MACROS_SVH

// implication checked every cycle outside reset
`define SVPD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define SVPD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/svpd_pkg.sv
// ----------------------------------------------------------------------------
// Space vector PWM duty package
// Widths, constants and sector codes shared by the duty pipeline.
// ----------------------------------------------------------------------------
package svpd_pkg;
   localparam int VOLT_BITS      = 16;
   localparam int DUTY_FRAC_BITS = 15;
   localparam int DUTY_W         = DUTY_FRAC_BITS + 1;
   localparam int QUO_BITS       = DUTY_FRAC_BITS + 1;
   localparam int SQ_W           = 2 * (VOLT_BITS + 1);
   localparam int N_W            = VOLT_BITS + 20;
   localparam int D_W            = VOLT_BITS + 18;
   localparam int DIV_STEPS      = QUO_BITS;
   localparam int LANE_LAT       = DIV_STEPS + 2;
   localparam int FRONT_LAT      = 3;
   localparam int TOTAL_LAT      = FRONT_LAT + LANE_LAT;
   localparam logic signed [17:0] SQRT3_Q = 18'sd113512;

   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

   localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_FRAC_BITS - 1);
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1) << DUTY_FRAC_BITS;

   typedef logic signed [VOLT_BITS-1:0] volt_type;
   typedef logic [VOLT_BITS-1:0]        bus_type;
   typedef logic [DUTY_W-1:0]           duty_type;
   typedef logic signed [N_W-1:0]       num_type;
endpackage

### src/svpd_if.sv
// ----------------------------------------------------------------------------
// Space vector PWM duty channels
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface svpd_req_if import svpd_pkg::*; ();
   logic     valid;
   logic     ready;
   volt_type volt_alpha;
   volt_type volt_beta;
   bus_type  bus_voltage;
   modport source (output valid, volt_alpha, volt_beta, bus_voltage, input ready);
   modport sink   (input valid, volt_alpha, volt_beta, bus_voltage, output ready);
endinterface

interface svpd_rsp_if import svpd_pkg::*; ();
   logic       valid;
   logic       ready;
   duty_type   phase_a_duty;
   duty_type   phase_b_duty;
   duty_type   phase_c_duty;
   logic [2:0] hex_sector;
   logic       bus_is_zero;
   modport source (output valid, phase_a_duty, phase_b_duty, phase_c_duty,
                   hex_sector, bus_is_zero, input ready);
   modport sink   (input valid, phase_a_duty, phase_b_duty, phase_c_duty,
                   hex_sector, bus_is_zero, output ready);
endinterface

### src/svpd_front.sv
// ----------------------------------------------------------------------------
// Space vector PWM duty front end
// Three stages: capture, products, sector and per-phase numerators.
// ----------------------------------------------------------------------------
module svpd_front import svpd_pkg::*; (
   input  logic       clock,
   input  logic       advance,
   input  volt_type   volt_alpha,
   input  volt_type   volt_beta,
   input  bus_type    bus_voltage,
   output num_type    num_a,
   output num_type    num_b,
   output num_type    num_c,
   output logic [2:0] sector,
   output bus_type    bus_out
);
   volt_type va_ff, vb_ff;
   bus_type  bus0_ff, bus1_ff, bus2_ff;
   logic [SQ_W-1:0] a2_ff, b2_ff, a2_in, b2_in;
   num_type p_ff, q_ff, p_in, q_in;
   logic    aneg_ff, bneg_ff;
   num_type na_ff, nb_ff, nc_ff, na_in, nb_in, nc_in;
   logic [2:0] sec_ff, sec_in;
   logic [VOLT_BITS:0] ma, mb;
   logic signed [VOLT_BITS+1:0] va3;
   logic signed [VOLT_BITS+17:0] qprod;
   logic [SQ_W+1:0] a2x3;
   num_type q3;

   always_comb begin
      ma    = va_ff[VOLT_BITS-1] ? (VOLT_BITS+1)'(-{va_ff[VOLT_BITS-1], va_ff})
                                 : {1'b0, va_ff};
      mb    = vb_ff[VOLT_BITS-1] ? (VOLT_BITS+1)'(-{vb_ff[VOLT_BITS-1], vb_ff})
                                 : {1'b0, vb_ff};
      a2_in = ma * ma;
      b2_in = mb * mb;
      va3   = ((VOLT_BITS+2)'(va_ff) <<< 1) + (VOLT_BITS+2)'(va_ff);
      p_in  = N_W'($signed({va3, 16'b0}));
      qprod = (VOLT_BITS+18)'(vb_ff) * (VOLT_BITS+18)'(SQRT3_Q);
      q_in  = N_W'(qprod);
   end

   always_comb begin
      a2x3 = ((SQ_W+2)'(a2_ff) << 1) + (SQ_W+2)'(a2_ff);
      if (!bneg_ff) begin
         if (!aneg_ff) sec_in = ((SQ_W+2)'(b2_ff) > a2x3) ? SECTOR_2 : SECTOR_1;
         else          sec_in = (a2x3 > (SQ_W+2)'(b2_ff)) ? SECTOR_3 : SECTOR_2;
      end else begin
         if (!aneg_ff) sec_in = ((SQ_W+2)'(b2_ff) > a2x3) ? SECTOR_5 : SECTOR_6;
         else          sec_in = (a2x3 > (SQ_W+2)'(b2_ff)) ? SECTOR_4 : SECTOR_5;
      end
      q3 = (q_ff <<< 1) + q_ff;
      case (sec_in)
         SECTOR_1, SECTOR_4: begin
            na_in = p_ff + q_ff;
            nb_in = q3 - p_ff;
            nc_in = -(p_ff + q_ff);
         end
         SECTOR_2, SECTOR_5: begin
            na_in = p_ff <<< 1;
            nb_in = q_ff <<< 1;
            nc_in = -(q_ff <<< 1);
         end
         default: begin
            na_in = p_ff - q_ff;
            nb_in = q_ff - p_ff;
            nc_in = -p_ff - q3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         va_ff   <= volt_alpha;
         vb_ff   <= volt_beta;
         bus0_ff <= bus_voltage;
         a2_ff   <= a2_in;
         b2_ff   <= b2_in;
         p_ff    <= p_in;
         q_ff    <= q_in;
         aneg_ff <= va_ff[VOLT_BITS-1];
         bneg_ff <= vb_ff[VOLT_BITS-1];
         bus1_ff <= bus0_ff;
         na_ff   <= na_in;
         nb_ff   <= nb_in;
         nc_ff   <= nc_in;
         sec_ff  <= sec_in;
         bus2_ff <= bus1_ff;
      end
   end

   assign num_a   = na_ff;
   assign num_b   = nb_ff;
   assign num_c   = nc_ff;
   assign sector  = sec_ff;
   assign bus_out = bus2_ff;
endmodule

### src/svpd_lane.sv
// ----------------------------------------------------------------------------
// Space vector PWM duty divider lane
// Pipelined restoring division of one numerator by the bus, one bit a stage.
// ----------------------------------------------------------------------------
module svpd_lane import svpd_pkg::*; (
   input  logic     clock,
   input  logic     advance,
   input  num_type  num,
   input  bus_type  bus,
   output duty_type duty
);
   logic [D_W-1:0]      r_ff [0:DIV_STEPS];
   logic [D_W-1:0]      r_in [1:DIV_STEPS];
   logic [D_W-1:0]      d_ff [0:DIV_STEPS];
   logic [QUO_BITS-1:0] q_ff [0:DIV_STEPS];
   logic [QUO_BITS-1:0] q_in [1:DIV_STEPS];
   logic [DIV_STEPS:0]  neg_ff, sat_ff, zero_ff;
   logic [N_W-1:0]      mag;
   logic [D_W-1:0]      d0;
   logic                sat0;
   logic [D_W:0]        r2, diff;
   logic                ge;
   logic [QUO_BITS:0]   qr;
   duty_type            duty_ff, duty_in;
   logic [DUTY_W-1:0]   qh;

   always_comb begin
      mag  = num[N_W-1] ? N_W'(-num) : N_W'(num);
      d0   = {bus, 18'b0};
      sat0 = ({1'b0, mag, 1'b0} >= (N_W+2)'(d0));
      for (int k = 1; k <= DIV_STEPS; k++) begin
         r2      = {r_ff[k-1], 1'b0};
         diff    = r2 - {1'b0, d_ff[k-1]};
         ge      = (r2 >= {1'b0, d_ff[k-1]});
         r_in[k] = ge ? diff[D_W-1:0] : r2[D_W-1:0];
         q_in[k] = {q_ff[k-1][QUO_BITS-2:0], ge};
      end
      qr = ({1'b0, q_ff[DIV_STEPS]} + (QUO_BITS+1)'(1)) >> 1;
      qh = DUTY_W'(qr);
      if (zero_ff[DIV_STEPS])     duty_in = DUTY_HALF;
      else if (sat_ff[DIV_STEPS]) duty_in = neg_ff[DIV_STEPS] ? '0 : DUTY_FULL;
      else if (neg_ff[DIV_STEPS]) duty_in = DUTY_HALF - qh;
      else                        duty_in = DUTY_HALF + qh;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff[0]    <= mag[D_W-1:0];
         d_ff[0]    <= d0;
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[N_W-1];
         sat_ff[0]  <= sat0;
         zero_ff[0] <= (bus == '0);
         for (int k = 1; k <= DIV_STEPS; k++) begin
            r_ff[k]    <= r_in[k];
            d_ff[k]    <= d_ff[k-1];
            q_ff[k]    <= q_in[k];
            neg_ff[k]  <= neg_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;
endmodule

### src/space_vector_pwm_duty_top.sv
// Depth: 21 register stages from request capture to the registered response.
// Throughput: one request per cycle while the response is not stalled; the 16-stage bit-per-stage divider sets depth.
// A stalled response freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// Space vector PWM duty top
// Sector search and centre-aligned three-phase duty generation.
// ----------------------------------------------------------------------------
`include "space_vector_pwm_duty_top_macros.svh"

module space_vector_pwm_duty_top import svpd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   svpd_req_if.sink    req_chan,
   svpd_rsp_if.source  rsp_chan
);
   logic [TOTAL_LAT-1:0] valid_ff, valid_in;
   logic [2:0]  sec_ff [0:LANE_LAT-1];
   logic        zero_ff [0:LANE_LAT-1];
   logic        advance;
   num_type     num_a, num_b, num_c;
   logic [2:0]  sector;
   bus_type     bus;

   assign advance  = !valid_ff[TOTAL_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_in = {valid_ff[TOTAL_LAT-2:0], req_chan.valid};

   svpd_front u_front (
      .clock(clock), .advance(advance),
      .volt_alpha(req_chan.volt_alpha), .volt_beta(req_chan.volt_beta),
      .bus_voltage(req_chan.bus_voltage),
      .num_a(num_a), .num_b(num_b), .num_c(num_c),
      .sector(sector), .bus_out(bus)
   );

   svpd_lane u_lane_a (.clock(clock), .advance(advance), .num(num_a), .bus(bus),
                       .duty(rsp_chan.phase_a_duty));
   svpd_lane u_lane_b (.clock(clock), .advance(advance), .num(num_b), .bus(bus),
                       .duty(rsp_chan.phase_b_duty));
   svpd_lane u_lane_c (.clock(clock), .advance(advance), .num(num_c), .bus(bus),
                       .duty(rsp_chan.phase_c_duty));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sec_ff[0]  <= sector;
         zero_ff[0] <= (bus == '0);
         for (int k = 1; k < LANE_LAT; k++) begin
            sec_ff[k]  <= sec_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign rsp_chan.valid       = valid_ff[TOTAL_LAT-1];
   assign rsp_chan.hex_sector  = sec_ff[LANE_LAT-1];
   assign rsp_chan.bus_is_zero = zero_ff[LANE_LAT-1];

   `SVPD_ASSERT_IMP(a_duty_range, rsp_chan.valid,
      (rsp_chan.phase_a_duty <= DUTY_FULL) && (rsp_chan.phase_b_duty <= DUTY_FULL) &&
      (rsp_chan.phase_c_duty <= DUTY_FULL), "duty above full scale")
   `SVPD_ASSERT_IMP(a_sector_range, rsp_chan.valid,
      (rsp_chan.hex_sector >= SECTOR_1) && (rsp_chan.hex_sector <= SECTOR_6),
      "sector out of range")
   `SVPD_ASSERT_IMP(a_zero_half, rsp_chan.valid && rsp_chan.bus_is_zero,
      (rsp_chan.phase_a_duty == DUTY_HALF) && (rsp_chan.phase_b_duty == DUTY_HALF) &&
      (rsp_chan.phase_c_duty == DUTY_HALF), "zero bus without half duty")
   `SVPD_ASSERT_NXT(a_stall_freeze, !advance, $stable(valid_ff),
      "pipeline moved while stalled")
endmodule
